### rtl/direct_mapped_write_through_cache_top_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef DIRECT_MAPPED_WRITE_THROUGH_CACHE_TOP_MACROS_SVH
`define DIRECT_MAPPED_WRITE_THROUGH_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define DMC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define DMC_ASSERT_NEVER(label, prop) \
  `DMC_ASSERT(label, !(prop))
`else
`define DMC_ASSERT(label, prop)
`define DMC_ASSERT_NEVER(label, prop)
`endif

`endif

### rtl/dmc_pkg.sv
package dmc_pkg;

  localparam int unsigned LINE_WORDS = 4;
  localparam int unsigned OFFSET_W   = $clog2(LINE_WORDS);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned LAT_W      = 9;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CFG_W-1:0] HIT_LAT_RST = 8'd4;
  localparam logic [CFG_W-1:0] MEM_LAT_RST = 8'd100;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef enum logic [0:0] {
    REG_HIT_LATENCY    = 1'b0,
    REG_MEMORY_LATENCY = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic [CFG_W-1:0] hit_latency;
    logic [CFG_W-1:0] memory_latency;
  } cfg_t;

endpackage

### rtl/dmc_req_if.sv
interface dmc_req_if #(
  parameter int unsigned ADDR_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [ADDR_BITS-1:0]   address;
  dmc_pkg::word_t         write_data;
  dmc_pkg::word_t         fill_word0;
  dmc_pkg::word_t         fill_word1;
  dmc_pkg::word_t         fill_word2;
  dmc_pkg::word_t         fill_word3;

  modport source (
    output valid, func, address, write_data, fill_word0, fill_word1, fill_word2, fill_word3,
    input  ready
  );
  modport sink (
    input  valid, func, address, write_data, fill_word0, fill_word1, fill_word2, fill_word3,
    output ready
  );
endinterface

### rtl/dmc_rsp_if.sv
interface dmc_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  dmc_pkg::word_t             data_word;
  dmc_pkg::word_t             line_word0;
  dmc_pkg::word_t             line_word1;
  dmc_pkg::word_t             line_word2;
  dmc_pkg::word_t             line_word3;
  logic [dmc_pkg::LAT_W-1:0]  latency;
  logic                       memory_write;
  logic [dmc_pkg::CNT_W-1:0]  hit_total;
  logic [dmc_pkg::CNT_W-1:0]  miss_total;

  modport source (
    output valid, hit, data_word, line_word0, line_word1, line_word2, line_word3,
           latency, memory_write, hit_total, miss_total,
    input  ready
  );
  modport sink (
    input  valid, hit, data_word, line_word0, line_word1, line_word2, line_word3,
           latency, memory_write, hit_total, miss_total,
    output ready
  );
endinterface

### rtl/dmc_ram.sv
module dmc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dmc_cfg.sv
module dmc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [dmc_pkg::PDATA_W-1:0]   pwdata,
  output logic [dmc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output dmc_pkg::cfg_t                 cfg_o
);

  dmc_pkg::reg_idx_e reg_idx;
  dmc_pkg::cfg_t     cfg_d, cfg_q;
  logic              wr_en;

  assign reg_idx = dmc_pkg::reg_idx_e'(paddr[dmc_pkg::PADDR_W-1]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        dmc_pkg::REG_HIT_LATENCY:    cfg_d.hit_latency    = pwdata[dmc_pkg::CFG_W-1:0];
        dmc_pkg::REG_MEMORY_LATENCY: cfg_d.memory_latency = pwdata[dmc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dmc_pkg::REG_HIT_LATENCY:
        prdata = dmc_pkg::PDATA_W'(cfg_q.hit_latency);
      dmc_pkg::REG_MEMORY_LATENCY:
        prdata = dmc_pkg::PDATA_W'(cfg_q.memory_latency);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hit_latency    <= dmc_pkg::HIT_LAT_RST;
      cfg_q.memory_latency <= dmc_pkg::MEM_LAT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/dmc_ctrl.sv
module dmc_ctrl #(
  parameter int unsigned NUM_LINES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  dmc_pkg::sts_t                sts_i,
  output logic                         in_ready_o,
  output dmc_pkg::cmd_t                cmd_o,
  output logic [$clog2(NUM_LINES)-1:0] clr_idx_o
);

  localparam int unsigned IDX_W = $clog2(NUM_LINES);

  dmc_pkg::state_e  state_d, state_q;
  logic [IDX_W-1:0] clr_idx_d, clr_idx_q;

  always_comb begin
    state_d    = state_q;
    clr_idx_d  = clr_idx_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dmc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        clr_idx_d   = clr_idx_q + 1'b1;
        if (clr_idx_q == IDX_W'(NUM_LINES - 1)) begin
          state_d = dmc_pkg::ST_IDLE;
        end
      end
      dmc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dmc_pkg::ST_LOOKUP;
        end
      end
      dmc_pkg::ST_LOOKUP: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = dmc_pkg::ST_IDLE;
        end
      end
      default: state_d = dmc_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dmc_pkg::ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  assign clr_idx_o = clr_idx_q;

endmodule

### rtl/dmc_dp.sv
module dmc_dp #(
  parameter int unsigned NUM_LINES = 64,
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dmc_pkg::cmd_t                cmd_i,
  input  logic [$clog2(NUM_LINES)-1:0] clr_idx_i,
  input  logic                         func_i,
  input  logic [ADDR_BITS-1:0]         address_i,
  input  dmc_pkg::word_t               write_data_i,
  input  dmc_pkg::word_t               fill_word_i [dmc_pkg::LINE_WORDS],
  input  dmc_pkg::cfg_t                cfg_i,
  output dmc_pkg::sts_t                sts_o,
  dmc_rsp_if.source                    rsp_o
);

  localparam int unsigned IDX_W   = $clog2(NUM_LINES);
  localparam int unsigned OFF_W   = dmc_pkg::OFFSET_W;
  localparam int unsigned TAG_RAW = ADDR_BITS - OFF_W - IDX_W;
  localparam int unsigned TAG_W   = (ADDR_BITS > OFF_W + IDX_W) ? TAG_RAW : 1;
  localparam int unsigned EXT_W   = OFF_W + IDX_W + TAG_W;
  localparam int unsigned LW      = dmc_pkg::LINE_WORDS;
  localparam int unsigned LAT_W   = dmc_pkg::LAT_W;
  localparam int unsigned CNT_W   = dmc_pkg::CNT_W;

  logic [EXT_W-1:0]  addr_ext;
  logic [IDX_W-1:0]  idx_in;
  logic              is_write_q;
  logic [OFF_W-1:0]  off_q;
  logic [IDX_W-1:0]  idx_q;
  logic [TAG_W-1:0]  tag_q;
  dmc_pkg::word_t    wdata_q;
  dmc_pkg::word_t    fill_q [LW];

  logic [IDX_W-1:0]  ram_addr;
  logic              tag_we;
  logic [TAG_W:0]    tag_wdata;
  logic [TAG_W:0]    tag_rdata;
  dmc_pkg::word_t    data_rdata [LW];
  logic [LW-1:0]     data_we;

  logic              hit;
  dmc_pkg::word_t    line [LW];
  dmc_pkg::word_t    word;
  logic [LAT_W-1:0]  lat;

  logic              rsp_valid_d, rsp_valid_q;
  logic              hit_q;
  dmc_pkg::word_t    word_q;
  dmc_pkg::word_t    line_q [LW];
  logic [LAT_W-1:0]  lat_q;
  logic              mem_wr_q;
  logic [CNT_W-1:0]  hit_cnt_q, miss_cnt_q;

  assign addr_ext = EXT_W'(address_i);
  assign idx_in   = addr_ext[OFF_W +: IDX_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_write_q <= (func_i == dmc_pkg::FUNC_WRITE);
      off_q      <= addr_ext[OFF_W-1:0];
      idx_q      <= idx_in;
      tag_q      <= addr_ext[OFF_W + IDX_W +: TAG_W];
      wdata_q    <= write_data_i;
      fill_q     <= fill_word_i;
    end
  end

  always_comb begin
    priority if (cmd_i.clear) begin
      ram_addr = clr_idx_i;
    end else if (cmd_i.load) begin
      ram_addr = idx_in;
    end else begin
      ram_addr = idx_q;
    end
  end

  assign hit       = tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == tag_q);
  assign tag_we    = cmd_i.clear | (cmd_i.commit & ~is_write_q & ~hit);
  assign tag_wdata = cmd_i.clear ? '0 : {1'b1, tag_q};

  dmc_ram #(
    .WIDTH (TAG_W + 1),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .re_i    (cmd_i.load),
    .addr_i  (ram_addr),
    .wdata_i (tag_wdata),
    .rdata_o (tag_rdata)
  );

  for (genvar k = 0; k < LW; k++) begin : g_data
    assign data_we[k] = cmd_i.commit &
                        ((~is_write_q & ~hit) | (is_write_q & hit & (off_q == OFF_W'(k))));
    dmc_ram #(
      .WIDTH (dmc_pkg::DATA_W),
      .DEPTH (NUM_LINES)
    ) u_data_ram (
      .clk_i   (clk_i),
      .we_i    (data_we[k]),
      .re_i    (cmd_i.load),
      .addr_i  (ram_addr),
      .wdata_i (is_write_q ? wdata_q : fill_q[k]),
      .rdata_o (data_rdata[k])
    );
    assign line[k] = is_write_q ? '0 : (hit ? data_rdata[k] : fill_q[k]);
  end

  assign word = is_write_q ? wdata_q : line[off_q];

  always_comb begin
    priority if (!is_write_q && hit) begin
      lat = LAT_W'(cfg_i.hit_latency);
    end else if (is_write_q && !hit) begin
      lat = LAT_W'(cfg_i.memory_latency);
    end else begin
      lat = LAT_W'(cfg_i.hit_latency) + LAT_W'(cfg_i.memory_latency);
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_i.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (cmd_i.commit) begin
        if (hit) begin
          hit_cnt_q <= hit_cnt_q + 1'b1;
        end else begin
          miss_cnt_q <= miss_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q    <= hit;
      word_q   <= word;
      line_q   <= line;
      lat_q    <= lat;
      mem_wr_q <= is_write_q;
    end
  end

  assign sts_o.out_busy   = rsp_valid_q & ~rsp_o.ready;

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.hit          = hit_q;
  assign rsp_o.data_word    = word_q;
  assign rsp_o.line_word0   = line_q[0];
  assign rsp_o.line_word1   = line_q[1];
  assign rsp_o.line_word2   = line_q[2];
  assign rsp_o.line_word3   = line_q[3];
  assign rsp_o.latency      = lat_q;
  assign rsp_o.memory_write = mem_wr_q;
  assign rsp_o.hit_total    = hit_cnt_q;
  assign rsp_o.miss_total   = miss_cnt_q;

endmodule

### rtl/direct_mapped_write_through_cache_top.sv
// A result is registered when its accepted transaction commits, after the tag and data RAM
// reads; a held result stalls the commit only. The single-port tag and data RAMs are read when
// an access is accepted and updated when it commits; no new access is accepted before then.
// Reset: asynchronous, active low; afterwards a clearing pass invalidates all NUM_LINES
// tag RAM entries while no access is accepted. Configuration writes are taken at all times.
`include "direct_mapped_write_through_cache_top_macros.svh"

module direct_mapped_write_through_cache_top #(
  parameter int unsigned NUM_LINES = 64,
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dmc_req_if.sink                     req_i,
  dmc_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmc_pkg::PADDR_W-1:0] paddr,
  input  logic [dmc_pkg::PDATA_W-1:0] pwdata,
  output logic [dmc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  // NUM_LINES must be a power of two; the block itself does not enforce it.
  localparam int unsigned IDX_W = $clog2(NUM_LINES);

  dmc_pkg::cmd_t  cmd;
  dmc_pkg::sts_t  sts;
  dmc_pkg::cfg_t  cfg;
  logic [IDX_W-1:0] clr_idx;
  logic           in_ready;
  dmc_pkg::word_t fill [dmc_pkg::LINE_WORDS];

  assign req_i.ready = in_ready;
  assign fill[0] = req_i.fill_word0;
  assign fill[1] = req_i.fill_word1;
  assign fill[2] = req_i.fill_word2;
  assign fill[3] = req_i.fill_word3;

  dmc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dmc_ctrl #(
    .NUM_LINES (NUM_LINES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .clr_idx_o  (clr_idx)
  );

  dmc_dp #(
    .NUM_LINES (NUM_LINES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .clr_idx_i    (clr_idx),
    .func_i       (req_i.func),
    .address_i    (req_i.address),
    .write_data_i (req_i.write_data),
    .fill_word_i  (fill),
    .cfg_i        (cfg),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

  `DMC_ASSERT(a_commit_gives_result, cmd.commit |=> rsp_o.valid)
  `DMC_ASSERT(a_accept_then_busy, (req_i.valid && req_i.ready) |=> !req_i.ready)
  `DMC_ASSERT_NEVER(a_no_overwrite, cmd.commit && rsp_o.valid && !rsp_o.ready)
  `DMC_ASSERT_NEVER(a_no_accept_in_clear, cmd.clear && req_i.ready)

endmodule
